>>> sv/frc_pkg.sv
// Shared types and constants for the framed circle rasterizer.
package frc_pkg;

  localparam int COORD_WIDTH = 10;
  localparam int PIX_W       = 12;
  localparam int RAD_W       = 9;
  localparam int THK_W       = 8;
  localparam int COLOR_W     = 18;
  localparam int OFS_W       = RAD_W + 1;
  localparam int SQ_W        = 2 * RAD_W;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_t;

  typedef struct packed {
    op_t                    op;
    logic [COORD_WIDTH-1:0] center_x;
    logic [COORD_WIDTH-1:0] center_y;
    logic [RAD_W-1:0]       radius;
    logic [THK_W-1:0]       thickness;
    logic [COLOR_W-1:0]     fill_color;
    logic [COLOR_W-1:0]     frame_color;
  } in_word_t;

  typedef struct packed {
    logic signed [PIX_W-1:0] pixel_x;
    logic signed [PIX_W-1:0] pixel_y;
    logic                    draw;
    logic                    on_border;
    logic [COLOR_W-1:0]      pixel_color;
    logic                    last;
  } out_word_t;

  // Held circle and current scan offsets from the center.
  typedef struct packed {
    logic signed [OFS_W-1:0] dx;
    logic signed [OFS_W-1:0] dy;
    logic [COORD_WIDTH-1:0]  center_x;
    logic [COORD_WIDTH-1:0]  center_y;
    logic [RAD_W-1:0]        radius;
    logic [SQ_W-1:0]         outer_sq;
    logic [SQ_W-1:0]         inner_sq;
    logic [COLOR_W-1:0]      fill;
    logic [COLOR_W-1:0]      frame;
  } scan_state_t;

endpackage

>>> sv/frc_scan.sv
// Scan sequencer: loads a circle on start and walks the bounding square on steps.
module frc_scan (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                step,
  input  frc_pkg::in_word_t   in_word,
  output logic                busy,
  output frc_pkg::scan_state_t scan
);
  import frc_pkg::*;

  logic                      busy_r, busy_nxt;
  scan_state_t               st_r, st_nxt;
  logic signed [OFS_W-1:0]   r_s, r_m1, r_in, diff;
  logic signed [2*OFS_W-1:0] diff_sq;
  logic [SQ_W-1:0]           r_sq;

  always_comb begin
    r_s     = $signed({1'b0, st_r.radius});
    r_m1    = r_s - $signed(OFS_W'(1));
    r_in    = $signed({1'b0, in_word.radius});
    diff    = r_in - $signed({2'b00, in_word.thickness});
    diff_sq = (2*OFS_W)'(diff) * (2*OFS_W)'(diff);
    r_sq    = SQ_W'(in_word.radius) * SQ_W'(in_word.radius);

    st_nxt   = st_r;
    busy_nxt = busy_r;
    if (start) begin
      st_nxt.dx       = -r_in;
      st_nxt.dy       = -r_in;
      st_nxt.center_x = in_word.center_x;
      st_nxt.center_y = in_word.center_y;
      st_nxt.radius   = in_word.radius;
      st_nxt.outer_sq = r_sq;
      st_nxt.inner_sq = diff_sq[SQ_W-1:0];
      st_nxt.fill     = in_word.fill_color;
      st_nxt.frame    = in_word.frame_color;
      busy_nxt        = (in_word.radius != '0);
    end else if (step && busy_r) begin
      // advance row; wrap to the next column at the bottom edge
      if (st_r.dy == r_m1) begin
        st_nxt.dy = -r_s;
        st_nxt.dx = st_r.dx + $signed(OFS_W'(1));
        if (st_r.dx == r_m1) busy_nxt = 1'b0;
      end else begin
        st_nxt.dy = st_r.dy + $signed(OFS_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    st_r <= st_nxt;
  end

  assign busy = busy_r;
  assign scan = st_r;

endmodule

>>> sv/frc_shade.sv
// Pixel shader: distance test against both squares and color choice for one position.
module frc_shade (
  input  frc_pkg::scan_state_t scan,
  output frc_pkg::out_word_t   res
);
  import frc_pkg::*;

  logic signed [2*OFS_W-1:0] sq_x, sq_y;
  logic [SQ_W:0]             d_sq;
  logic signed [OFS_W-1:0]   r_m1;
  logic                      draw, border;

  always_comb begin
    sq_x   = (2*OFS_W)'(scan.dx) * (2*OFS_W)'(scan.dx);
    sq_y   = (2*OFS_W)'(scan.dy) * (2*OFS_W)'(scan.dy);
    d_sq   = {1'b0, sq_x[SQ_W-1:0]} + {1'b0, sq_y[SQ_W-1:0]};
    r_m1   = $signed({1'b0, scan.radius}) - $signed(OFS_W'(1));
    draw   = d_sq < {1'b0, scan.outer_sq};
    border = draw && (d_sq >= {1'b0, scan.inner_sq});

    res.pixel_x     = $signed(PIX_W'(scan.center_x)) + PIX_W'(scan.dx);
    res.pixel_y     = $signed(PIX_W'(scan.center_y)) + PIX_W'(scan.dy);
    res.draw        = draw;
    res.on_border   = border;
    res.pixel_color = !draw ? '0 : (border ? scan.frame : scan.fill);
    res.last        = (scan.dx == r_m1) && (scan.dy == r_m1);
  end

endmodule

>>> sv/framed_circle_rasterizer_unit.sv
// A step word's pixel appears in the output register in the cycle after its acceptance.
// Throughput: one word per cycle while in_stall is low; a start word gives no pixel, each step while busy gives one.
// A circle of radius r yields 4*r*r pixels, one per accepted step.
// Input stalls only while a held pixel is not taken.
// Reset (rst_n low, synchronous) clears busy and the output valid; no pixel is pending.
module framed_circle_rasterizer_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  frc_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output frc_pkg::out_word_t out_word
);
  import frc_pkg::*;

  logic        in_acc, start, step, busy, load;
  scan_state_t scan;
  out_word_t   res;
  out_word_t   out_word_r;
  logic        out_valid_r, out_valid_nxt;

  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;
  assign start    = in_acc && (in_word.op == OP_START);
  assign step     = in_acc && (in_word.op == OP_STEP);
  assign load     = step && busy;

  frc_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .step    (step),
    .in_word (in_word),
    .busy    (busy),
    .scan    (scan)
  );

  frc_shade u_shade (
    .scan (scan),
    .res  (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (!out_valid_r || !out_stall) out_valid_nxt = load;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (load) out_word_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

>>> sv/frc_checker.sv
// Port-level checker for the framed circle rasterizer, bound to the top level.
module frc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input frc_pkg::in_word_t  in_word,
  input logic               out_valid,
  input logic               out_stall,
  input frc_pkg::out_word_t out_word
);
  import frc_pkg::*;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("held output word changed under stall");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked output word");

  a_undrawn: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.draw |-> !out_word.on_border && (out_word.pixel_color == '0))
    else $error("undrawn pixel carries border or color");

  a_start_no_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_word.op == OP_START) && !out_valid |=> !out_valid)
    else $error("start word produced a pixel");

endmodule

bind framed_circle_rasterizer_unit frc_checker u_frc_checker (.*);

>>> tb/sv/testbench.sv
// Testbench for the framed circle rasterizer: random scans checked against a local predictor.
module testbench;
  import frc_pkg::*;

  localparam int HALF_PERIOD  = 6;
  localparam int RESET_CYCLES = 10;
  localparam int CALM_TAIL    = 200;
  localparam int LIMIT_CYCLES = 600000;
  localparam int RANDOM_WORDS = 1950;
  localparam int COLOR_MAX    = 2**COLOR_W - 1;

  typedef struct {
    in_word_t w;
    bit       drain;
  } feed_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  feed_t     word_q[$];
  out_word_t pixel_q[$];
  feed_t     next_feed;
  logic      in_taken = 1'b0;
  int        gap_left = 0;
  int        stall_left = 0;
  int        words_taken = 0;
  int        mismatches = 0;

  // Predictor state for the circle being scanned.
  logic        circle_busy = 1'b0;
  int          col_pos = 0;
  int          row_pos = 0;
  int          ctr_x = 0;
  int          ctr_y = 0;
  int          rad = 0;
  int          outer_sq = 0;
  int          inner_sq = 0;
  logic [COLOR_W-1:0] fill_c = '0;
  logic [COLOR_W-1:0] frame_c = '0;

  framed_circle_rasterizer_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic void rasterize_word(in_word_t w);
    out_word_t px;
    int dx;
    int dy;
    int dist_sq;
    int diff;
    if (w.op == OP_START) begin
      ctr_x = w.center_x;
      ctr_y = w.center_y;
      rad = w.radius;
      diff = rad - int'(w.thickness);
      outer_sq = rad * rad;
      // Negative difference squares to a positive inner bound.
      inner_sq = diff * diff;
      fill_c = w.fill_color;
      frame_c = w.frame_color;
      col_pos = ctr_x - rad;
      row_pos = ctr_y - rad;
      circle_busy = (rad != 0);
    end else if (circle_busy) begin
      dx = col_pos - ctr_x;
      dy = row_pos - ctr_y;
      dist_sq = dx * dx + dy * dy;
      px.pixel_x = PIX_W'(col_pos);
      px.pixel_y = PIX_W'(row_pos);
      px.draw = (dist_sq < outer_sq);
      px.on_border = px.draw && (dist_sq >= inner_sq);
      px.pixel_color = !px.draw ? '0 : (px.on_border ? frame_c : fill_c);
      px.last = (col_pos == ctr_x + rad - 1) && (row_pos == ctr_y + rad - 1);
      pixel_q.push_back(px);
      row_pos++;
      if (row_pos >= ctr_y + rad) begin
        row_pos = ctr_y - rad;
        col_pos++;
        if (col_pos >= ctr_x + rad) circle_busy = 1'b0;
      end
    end
  endfunction

  task automatic note_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic compare_pixel(out_word_t got);
    out_word_t want;
    if (pixel_q.size() == 0) begin
      note_mismatch("pixel word with no prediction pending");
    end else begin
      want = pixel_q.pop_front();
      if (got.pixel_x !== want.pixel_x)
        note_mismatch($sformatf("pixel_x got %0d want %0d", got.pixel_x, want.pixel_x));
      if (got.pixel_y !== want.pixel_y)
        note_mismatch($sformatf("pixel_y got %0d want %0d", got.pixel_y, want.pixel_y));
      if (got.draw !== want.draw)
        note_mismatch($sformatf("draw got %b want %b", got.draw, want.draw));
      if (got.on_border !== want.on_border)
        note_mismatch($sformatf("on_border got %b want %b", got.on_border, want.on_border));
      if (got.pixel_color !== want.pixel_color)
        note_mismatch($sformatf("pixel_color got %h want %h", got.pixel_color,
                                want.pixel_color));
      if (got.last !== want.last)
        note_mismatch($sformatf("last got %b want %b", got.last, want.last));
    end
  endtask

  function automatic in_word_t random_word();
    in_word_t w;
    w.op = op_t'($urandom_range(0, 1));
    w.center_x = COORD_WIDTH'($urandom_range(0, 2**COORD_WIDTH - 1));
    w.center_y = COORD_WIDTH'($urandom_range(0, 2**COORD_WIDTH - 1));
    w.radius = RAD_W'($urandom_range(0, 2**RAD_W - 1));
    w.thickness = THK_W'($urandom_range(0, 2**THK_W - 1));
    w.fill_color = COLOR_W'($urandom_range(0, COLOR_MAX));
    w.frame_color = COLOR_W'($urandom_range(0, COLOR_MAX));
    return w;
  endfunction

  function automatic void add_start(int cx, int cy, int r, int thk, int fill, int frame,
                                    bit drain);
    feed_t f;
    f.w = random_word();
    f.w.op = OP_START;
    f.w.center_x = COORD_WIDTH'(cx);
    f.w.center_y = COORD_WIDTH'(cy);
    f.w.radius = RAD_W'(r);
    f.w.thickness = THK_W'(thk);
    f.w.fill_color = COLOR_W'(fill);
    f.w.frame_color = COLOR_W'(frame);
    f.drain = drain;
    word_q.push_back(f);
  endfunction

  // Step words carry random junk in the fields the block ignores.
  function automatic void add_step();
    feed_t f;
    f.w = random_word();
    f.w.op = OP_STEP;
    f.drain = 1'b0;
    word_q.push_back(f);
  endfunction

  // Idle only outside the quiet stretches and the tail of the run.
  function automatic bit idle_allowed();
    return (word_q.size() >= CALM_TAIL) && ((words_taken / 128) % 4 != 3);
  endfunction

  // Monitor: check pixels and predict on every accepted input word.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (out_valid && !out_stall) compare_pixel(out_word);
      if (in_valid && !in_stall) begin
        rasterize_word(in_word);
        words_taken++;
      end
    end
  end

  // Input driver: hold a stalled word, otherwise take the next one after any gap.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (word_q.size() == 0 || (word_q[0].drain && pixel_q.size() != 0)) begin
        in_valid <= 1'b0;
      end else begin
        next_feed = word_q.pop_front();
        in_word <= next_feed.w;
        in_valid <= 1'b1;
        if (idle_allowed() && $urandom_range(0, 7) == 0) gap_left <= $urandom_range(1, 12);
      end
    end
  end

  // Output side stall bursts.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (rst_n && idle_allowed() && $urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 11);
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    int n_items;
    int pick;
    int r;
    int thk;
    int full;
    int steps;
    n_items = 0;

    // Zero radius, then a step while idle.
    add_start(1023, 0, 0, 255, COLOR_MAX, COLOR_MAX, 1'b0);
    add_step();
    // Smallest circle with no border, then a step past the end.
    add_start(0, 1023, 1, 0, COLOR_MAX, 0, 1'b0);
    repeat (4) add_step();
    add_step();
    // Largest radius at both corners; the second start drops the first scan.
    add_start(1023, 1023, 511, 255, 0, COLOR_MAX, 1'b0);
    repeat (3) add_step();
    add_start(0, 0, 511, 1, 'h2AAAA, 'h15555, 1'b0);
    repeat (3) add_step();
    // Border wider than the radius; hold this start until all pixels are back.
    add_start(512, 511, 1, 255, 'h15555, 'h2AAAA, 1'b1);
    repeat (4) add_step();

    while (n_items < RANDOM_WORDS) begin
      pick = $urandom_range(0, 39);
      if (pick == 0) r = 0;
      else if (pick == 1) r = $urandom_range(256, 511);
      else if (pick == 2) r = $urandom_range(7, 12);
      else r = $urandom_range(1, 6);
      if (r > 12 || $urandom_range(0, 3) == 0) thk = $urandom_range(0, 255);
      else thk = $urandom_range(0, r + 2);
      add_start($urandom_range(0, 1023), $urandom_range(0, 1023), r, thk,
                $urandom_range(0, COLOR_MAX), $urandom_range(0, COLOR_MAX),
                $urandom_range(0, 24) == 0);
      full = 4 * r * r;
      if (r == 0) steps = 0;
      else if (r > 12) steps = $urandom_range(1, 40);
      else if ($urandom_range(0, 5) == 0) steps = $urandom_range(0, full - 1);
      else steps = full;
      repeat (steps) add_step();
      n_items += 1 + steps;
      // Steps past the end of a scan are ignored by the block.
      if ((r == 0 || steps == full) && $urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 3)) add_step();
    end

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    wait (word_q.size() == 0);
    while (in_valid || pixel_q.size() != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #(LIMIT_CYCLES * 2 * HALF_PERIOD);
    $display("TIMEOUT: %0d predicted pixels outstanding", pixel_q.size());
    $display("Some tests failed");
    $finish;
  end

endmodule
